### rtl/core/wav_pcm16_stream_parser_top_macros.svh
// assertion helpers for the wave stream parser
// both sample on clk and stay quiet while rst_n is low
`ifndef WAV_PCM16_STREAM_PARSER_TOP_MACROS_SVH
`define WAV_PCM16_STREAM_PARSER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define WAVP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WAVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/wavp_pkg.sv
`timescale 1ns / 1ps
package wavp_pkg;

  typedef enum logic [2:0] {
    PH_HDR_OK,
    PH_HDR_BAD,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_PAD,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NOTWAVE,
    ST_BADFMT,
    ST_UNSUP,
    ST_BADDATA,
    ST_NODATA
  } status_t;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_CORE_BYTES = 32'd16;
  localparam logic [15:0] FMT_PCM        = 16'd1;
  localparam logic [15:0] PCM_BITS       = 16'd16;
  localparam logic [15:0] CHAN_MONO      = 16'd1;
  localparam logic [15:0] CHAN_STEREO    = 16'd2;

  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] IDX_RIFF_LAST  = 4'd3;
  localparam logic [IDX_W-1:0] IDX_HDR_LAST   = 4'd11;
  localparam logic [IDX_W-1:0] IDX_TAG_END    = 4'd4;
  localparam logic [IDX_W-1:0] IDX_CHUNK_LAST = 4'd7;
  localparam logic [IDX_W-1:0] IDX_FMT_LAST   = 4'd15;

  // one result item
  typedef struct packed {
    logic               valid;
    logic               frame_valid;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               done_res;
    status_t            status;
    logic [31:0]        rate_out;
    logic [30:0]        frame_total;
  } wavp_res_t;

endpackage

### rtl/core/wavp_in_if.sv
`timescale 1ns / 1ps
interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

### rtl/core/wavp_out_if.sv
`timescale 1ns / 1ps
interface wavp_out_if;
  logic               valid;
  logic               ready;
  logic               frame_valid;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               done_res;
  logic [2:0]         status;
  logic [31:0]        rate_out;
  logic [30:0]        frame_total;

  modport source (output valid, frame_valid, left_sample, right_sample, done_res, status,
                  rate_out, frame_total, input ready);
  modport sink (input valid, frame_valid, left_sample, right_sample, done_res, status,
                rate_out, frame_total, output ready);
endinterface

### rtl/core/wav_pcm16_stream_parser_top.sv
`timescale 1ns / 1ps
// a result is registered and appears on out_ch in the cycle after the byte that caused it
// throughput: one byte per cycle unless out_ch stalls; the output register refills on the cycle it drains
// a stall on out_ch holds in_ch.ready low only while a result waits untaken
// reset: synchronous, active low; parser goes back to waiting for the riff header
// and the output register empties
module wav_pcm16_stream_parser_top
  import wavp_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  wavp_in_if.sink   in_ch,
  wavp_out_if.source out_ch
);

`include "wav_pcm16_stream_parser_top_macros.svh"

  // handshake
  logic      in_ready;
  logic      in_xfer;
  logic      out_xfer;

  // parser result for the byte being taken this cycle
  wavp_res_t res;

  // output register, payload holds without reset
  logic      out_valid_r, out_valid_nxt;
  wavp_res_t out_res_r, out_res_nxt;

  // new byte taken whenever the output slot is free or draining this cycle
  assign in_ready = !out_valid_r || out_ch.ready;
  assign in_xfer  = in_ch.valid && in_ready;
  assign out_xfer = out_valid_r && out_ch.ready;

  assign in_ch.ready = in_ready;

  // all chunk walking, field capture and frame assembly
  wavp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_xfer),
    .command   (in_ch.command),
    .data_byte (in_ch.data_byte),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (in_xfer) begin
      // bytes that produce nothing simply let the register drain
      out_valid_nxt = res.valid;
      if (res.valid) out_res_nxt = res;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  // result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_valid  = out_res_r.frame_valid;
  assign out_ch.left_sample  = out_res_r.left_sample;
  assign out_ch.right_sample = out_res_r.right_sample;
  assign out_ch.done_res     = out_res_r.done_res;
  assign out_ch.status       = out_res_r.status;
  assign out_ch.rate_out     = out_res_r.rate_out;
  assign out_ch.frame_total  = out_res_r.frame_total;

  // every offered result carries a frame, a final status or both
  `WAVP_ASSERT_SAME(a_res_nonempty, out_valid_r,
    out_res_r.frame_valid || out_res_r.done_res,
    "result offered with neither frame nor done")

  // rate and count are only reported with an ok status
  `WAVP_ASSERT_SAME(a_fail_no_totals,
    out_valid_r && out_res_r.done_res && (out_res_r.status != ST_OK),
    (out_res_r.rate_out == 32'd0) && (out_res_r.frame_total == 31'd0),
    "totals reported with a failing status")

  // nothing follows the final status
  `WAVP_ASSERT_NEXT(a_done_last, out_xfer && out_res_r.done_res,
    !out_valid_r,
    "result produced after done transfer")

  // an empty output register never blocks the input
  `WAVP_ASSERT_SAME(a_ready_when_empty, !out_valid_r, in_ready,
    "input stalled with empty output register")

endmodule

### rtl/core/wavp_parser.sv
`timescale 1ns / 1ps
module wavp_parser
  import wavp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       command,
  input  logic [7:0] data_byte,
  output wavp_res_t  res
);

  phase_t           phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [31:0]      tag_r, tag_nxt;
  logic             pad_r, pad_nxt;
  logic [15:0]      fmt_r, fmt_nxt;
  logic [15:0]      chan_r, chan_nxt;
  logic [31:0]      rate_r, rate_nxt;
  logic [15:0]      bits_r, bits_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [15:0]      left_r, left_nxt;
  logic [30:0]      frames_r, frames_nxt;

  logic [31:0]      tag_new;
  logic [31:0]      rem_full;
  logic [31:0]      rem_dec;
  logic             supported;
  logic             hdr_bad;
  logic             do_done;
  status_t          done_st;
  logic [15:0]      sample;
  logic [IDX_W-1:0] idx_d;

  assign tag_new   = {tag_r[23:0], data_byte};
  assign rem_full  = {data_byte, rem_r[23:0]};
  assign rem_dec   = (rem_r != 32'd0) ? rem_r - 32'd1 : rem_r;
  assign sample    = {data_byte, low_r};
  assign supported = (fmt_r == FMT_PCM) && (bits_r == PCM_BITS) &&
                     ((chan_r == CHAN_MONO) || (chan_r == CHAN_STEREO));
  assign hdr_bad   = (phase_r == PH_HDR_BAD) ||
                     ((idx_r == IDX_RIFF_LAST) && (tag_new != TAG_RIFF));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR_OK;
      idx_r    <= '0;
      rem_r    <= '0;
      tag_r    <= '0;
      pad_r    <= 1'b0;
      fmt_r    <= '0;
      chan_r   <= '0;
      rate_r   <= '0;
      bits_r   <= '0;
      low_r    <= '0;
      left_r   <= '0;
      frames_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      rem_r    <= rem_nxt;
      tag_r    <= tag_nxt;
      pad_r    <= pad_nxt;
      fmt_r    <= fmt_nxt;
      chan_r   <= chan_nxt;
      rate_r   <= rate_nxt;
      bits_r   <= bits_nxt;
      low_r    <= low_nxt;
      left_r   <= left_nxt;
      frames_r <= frames_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    tag_nxt    = tag_r;
    pad_nxt    = pad_r;
    fmt_nxt    = fmt_r;
    chan_nxt   = chan_r;
    rate_nxt   = rate_r;
    bits_nxt   = bits_r;
    low_nxt    = low_r;
    left_nxt   = left_r;
    frames_nxt = frames_r;
    idx_d      = idx_r;
    do_done    = 1'b0;
    done_st    = ST_OK;
    res        = '0;

    if (step && (phase_r != PH_DONE)) begin
      if (command == CMD_END) begin
        do_done = 1'b1;
        unique case (phase_r) inside
          PH_HDR_OK, PH_HDR_BAD: done_st = ST_NOTWAVE;
          PH_FMT:                done_st = ST_BADFMT;
          PH_DATA:               done_st = ST_BADDATA;
          default:               done_st = ST_NODATA;
        endcase
      end else begin
        unique case (phase_r) inside
          PH_HDR_OK, PH_HDR_BAD: begin
            tag_nxt = tag_new;
            if (hdr_bad) phase_nxt = PH_HDR_BAD;
            if (idx_r >= IDX_HDR_LAST) begin
              if (hdr_bad || (tag_new != TAG_WAVE)) begin
                do_done = 1'b1;
                done_st = ST_NOTWAVE;
              end else begin
                phase_nxt = PH_CHUNK;
                idx_nxt   = '0;
              end
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          PH_CHUNK: begin
            // tag bytes first, then little-endian size
            if (idx_r < IDX_TAG_END) begin
              tag_nxt = tag_new;
              if (idx_r == '0) rem_nxt = '0;
            end else begin
              rem_nxt[8*idx_r[1:0] +: 8] = data_byte;
            end
            if (idx_r < IDX_CHUNK_LAST) begin
              idx_nxt = idx_r + 1'b1;
            end else begin
              idx_nxt = '0;
              rem_nxt = rem_full;
              pad_nxt = rem_full[0];
              if (tag_r == TAG_FMT) begin
                if (rem_full < FMT_CORE_BYTES) begin
                  do_done = 1'b1;
                  done_st = ST_BADFMT;
                end else begin
                  rem_nxt   = rem_full - FMT_CORE_BYTES;
                  phase_nxt = PH_FMT;
                end
              end else if (tag_r == TAG_DATA) begin
                if (!supported) begin
                  do_done = 1'b1;
                  done_st = ST_UNSUP;
                end else begin
                  pad_nxt    = 1'b0;
                  frames_nxt = '0;
                  rem_nxt    = {rem_full[31:1], 1'b0};
                  phase_nxt  = PH_DATA;
                  // a data chunk shorter than two bytes finishes at once
                  if (rem_full[31:1] == 31'd0) begin
                    do_done = 1'b1;
                    done_st = ST_OK;
                  end
                end
              end else if (rem_full == 32'd0) begin
                phase_nxt = PH_CHUNK;
                pad_nxt   = 1'b0;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end
          end
          PH_FMT: begin
            unique case (idx_r) inside
              4'd0:             fmt_nxt  = {8'h00, data_byte};
              4'd1:             fmt_nxt  = {data_byte, fmt_r[7:0]};
              4'd2:             chan_nxt = {8'h00, data_byte};
              4'd3:             chan_nxt = {data_byte, chan_r[7:0]};
              4'd4:             rate_nxt = {24'h000000, data_byte};
              4'd5, 4'd6, 4'd7: rate_nxt[8*idx_r[1:0] +: 8] = data_byte;
              4'd14:            bits_nxt = {8'h00, data_byte};
              4'd15:            bits_nxt = {data_byte, bits_r[7:0]};
              default:          ;
            endcase
            if (idx_r < IDX_FMT_LAST) begin
              idx_nxt = idx_r + 1'b1;
            end else if (rem_r == 32'd0) begin
              idx_nxt   = '0;
              phase_nxt = pad_r ? PH_PAD : PH_CHUNK;
              pad_nxt   = 1'b0;
            end else begin
              idx_nxt   = '0;
              phase_nxt = PH_SKIP;
            end
          end
          PH_SKIP: begin
            rem_nxt = rem_dec;
            if (rem_dec == 32'd0) begin
              idx_nxt   = '0;
              phase_nxt = pad_r ? PH_PAD : PH_CHUNK;
              pad_nxt   = 1'b0;
            end
          end
          PH_PAD: begin
            phase_nxt = PH_CHUNK;
            idx_nxt   = '0;
          end
          PH_DATA: begin
            // idx bit 0: high byte next, bit 1: left sample held
            if (!idx_r[0]) begin
              low_nxt = data_byte;
              idx_d   = idx_r | 4'd1;
            end else if (chan_r != CHAN_STEREO) begin
              res.valid        = 1'b1;
              res.frame_valid  = 1'b1;
              res.left_sample  = sample;
              res.right_sample = sample;
              frames_nxt       = frames_r + 31'd1;
              idx_d            = '0;
            end else if (!idx_r[1]) begin
              left_nxt = sample;
              idx_d    = 4'd2;
            end else begin
              res.valid        = 1'b1;
              res.frame_valid  = 1'b1;
              res.left_sample  = left_r;
              res.right_sample = sample;
              frames_nxt       = frames_r + 31'd1;
              idx_d            = '0;
            end
            idx_nxt = idx_d;
            rem_nxt = rem_dec;
            if (rem_dec == 32'd0) begin
              do_done = 1'b1;
              done_st = idx_d[1] ? ST_BADDATA : ST_OK;
            end
          end
          PH_DONE: ;
        endcase
      end

      if (do_done) begin
        phase_nxt    = PH_DONE;
        res.valid    = 1'b1;
        res.done_res = 1'b1;
        res.status   = done_st;
        if (done_st == ST_OK) begin
          res.rate_out    = rate_r;
          res.frame_total = frames_nxt;
        end
      end
    end
  end

endmodule
